/* rtl/assert_macros.svh */
// Assertion macros shared by the top and multiplier RTL files.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge
`define RBM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define RBM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define RBM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rbm_pkg.sv */
// Shared constants and types for the radix RSA block.
// No dependencies; the interfaces and the RTL modules import this package.
package rbm_pkg;

    // Field and register widths
    localparam int MOD_W      = 32;
    localparam int EXP_W      = 32;
    localparam int RADIX_W    = 9;
    localparam int LEN_W      = 4;
    localparam int SYM_W      = 8;
    localparam int DIG_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IN_LEN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LEN  = 3'd4;

    // Radix clamp limits
    localparam logic [RADIX_W-1:0] RADIX_MIN = 9'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 9'd256;

    // Status of a multi-cycle arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    typedef logic [MOD_W-1:0] mod_word_t;

endpackage

/* rtl/rbm_if.sv */
// Handshake channels of the radix RSA block: symbol input and digit output.
// Depends on rbm_pkg for the payload widths.
interface rbm_sym_if import rbm_pkg::*;;
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol_code;

    modport source (output valid, output symbol_code, input ready);
    modport sink   (input valid, input symbol_code, output ready);
endinterface

interface rbm_dig_if import rbm_pkg::*;;
    logic             valid;
    logic             ready;
    logic [DIG_W-1:0] digit_code;
    logic             block_end;

    modport source (output valid, output digit_code, output block_end, input ready);
    modport sink   (input valid, input digit_code, input block_end, output ready);
endinterface

/* rtl/rsa_block_modexp_radix_top.sv */
// Radix RSA block: packs symbols, computes acc^exponent mod modulus, emits digits.
// Symbol intake: 9-step serial multiply by radix, then add; no new symbol until done.
// Block end: reduce modulo n, then per exponent bit a multiply if it is set and a square,
// then split into digits by the radix (result 0 when n < 2, with no exponentiation).
// Digits leave one per cycle while the sink is ready.
// Asynchronous active-low reset clears the registers to their defaults and the block.
`include "assert_macros.svh"

module rsa_block_modexp_radix_top
    import rbm_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int MAX_BLOCK = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    rbm_sym_if.sink               sym,
    rbm_dig_if.source             dig,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int MUL_BITS   = (WORD_BITS > MOD_W) ? WORD_BITS : MOD_W;
    localparam int ELEN_W     = $clog2(MAX_BLOCK + 1);
    localparam int CMP_W      = ((ELEN_W > LEN_W) ? ELEN_W : LEN_W) + 1;
    localparam int IDX_W      = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int PACK_CNT_W = $clog2(RADIX_W);
    localparam logic [CMP_W-1:0] MAX_X = CMP_W'(MAX_BLOCK);

    // Sequencer states
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_PACK      = 4'd1;
    localparam logic [3:0] S_PACK_END  = 4'd2;
    localparam logic [3:0] S_RED_WAIT  = 4'd3;
    localparam logic [3:0] S_EXP_CHECK = 4'd4;
    localparam logic [3:0] S_MUL_WAIT  = 4'd5;
    localparam logic [3:0] S_SQR_GO    = 4'd6;
    localparam logic [3:0] S_SQR_WAIT  = 4'd7;
    localparam logic [3:0] S_DIV_GO    = 4'd8;
    localparam logic [3:0] S_DIV_WAIT  = 4'd9;
    localparam logic [3:0] S_EMIT      = 4'd10;

    // Configuration registers
    mod_word_t          modulus_reg;
    logic [EXP_W-1:0]   exponent_reg;
    logic [RADIX_W-1:0] radix_reg;
    logic [LEN_W-1:0]   in_len_reg;
    logic [LEN_W-1:0]   out_len_reg;

    logic [3:0]            state_reg, state_next;
    logic [WORD_BITS-1:0]  acc_reg, acc_next;
    logic [LEN_W-1:0]      count_reg, count_next;
    logic [PACK_CNT_W-1:0] pcnt_reg, pcnt_next;
    logic [CMP_W-1:0]      k_reg, k_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [WORD_BITS-1:0]  pack_reg, pack_next;
    logic [RADIX_W-1:0]    rad_sh_reg, rad_sh_next;
    logic [SYM_W-1:0]      code_reg, code_next;
    mod_word_t             bb_reg, bb_next;
    mod_word_t             r_reg, r_next;
    logic [EXP_W-1:0]      e_reg, e_next;
    logic [DIG_W-1:0]      digit_mem [MAX_BLOCK];
    logic [DIG_W-1:0]      digit_out_reg;

    logic [RADIX_W-1:0]   radix_eff;
    logic [CMP_W-1:0]     in_len_x, out_len_x, il_x, ol_x;
    logic [WORD_BITS-1:0] pack_step, packed_word;
    logic                 block_done, n_ok, emit_last;
    logic                 sym_ready, sym_fire, dig_valid, dig_fire;
    logic                 dig_we;
    logic [IDX_W-1:0]     dig_widx;

    logic                mul_start;
    mod_word_t           mul_a;
    logic [MUL_BITS-1:0] mul_b;
    unit_stat_t          mul_stat;
    mod_word_t           mul_res;

    logic               div_start;
    unit_stat_t         div_stat;
    mod_word_t          div_quo;
    logic [DIG_W-1:0]   div_rem;

    // Take configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= MOD_W'(2);
            exponent_reg <= EXP_W'(1);
            radix_reg    <= RADIX_MIN;
            in_len_reg   <= LEN_W'(1);
            out_len_reg  <= LEN_W'(1);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_MODULUS:  modulus_reg  <= cfg_wdata[MOD_W-1:0];
                REG_EXPONENT: exponent_reg <= cfg_wdata[EXP_W-1:0];
                REG_RADIX:    radix_reg    <= cfg_wdata[RADIX_W-1:0];
                REG_IN_LEN:   in_len_reg   <= cfg_wdata[LEN_W-1:0];
                REG_OUT_LEN:  out_len_reg  <= cfg_wdata[LEN_W-1:0];
                default:      ;
            endcase
        end
    end

    // Clamp radix and block lengths to their working ranges
    always_comb
    begin
        if (radix_reg < RADIX_MIN)
            radix_eff = RADIX_MIN;
        else if (radix_reg > RADIX_MAX)
            radix_eff = RADIX_MAX;
        else
            radix_eff = radix_reg;
        in_len_x  = CMP_W'(in_len_reg);
        out_len_x = CMP_W'(out_len_reg);
        if (in_len_x == '0)
            il_x = CMP_W'(1);
        else if (in_len_x > MAX_X)
            il_x = MAX_X;
        else
            il_x = in_len_x;
        if (out_len_x == '0)
            ol_x = CMP_W'(1);
        else if (out_len_x > MAX_X)
            ol_x = MAX_X;
        else
            ol_x = out_len_x;
    end

    assign pack_step   = {pack_reg[WORD_BITS-2:0], 1'b0}
                         + (rad_sh_reg[RADIX_W-1] ? acc_reg : '0);
    assign packed_word = pack_reg + WORD_BITS'(code_reg);
    assign block_done  = (CMP_W'(count_reg) + 1'b1) >= il_x;
    assign n_ok        = modulus_reg >= MOD_W'(2);
    assign emit_last   = (CMP_W'(idx_reg) + 1'b1) == ol_x;
    assign dig_widx    = IDX_W'(k_reg - 1'b1);

    assign sym_ready = state_reg == S_IDLE;
    assign dig_valid = state_reg == S_EMIT;
    assign sym_fire  = sym.valid && sym_ready;
    assign dig_fire  = dig_valid && dig.ready;

    // Sequence packing, exponentiation, digit split and emission
    always_comb
    begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        count_next  = count_reg;
        pcnt_next   = pcnt_reg;
        k_next      = k_reg;
        idx_next    = idx_reg;
        pack_next   = pack_reg;
        rad_sh_next = rad_sh_reg;
        code_next   = code_reg;
        bb_next     = bb_reg;
        r_next      = r_reg;
        e_next      = e_reg;
        dig_we      = 1'b0;
        mul_start   = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        div_start   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (sym_fire)
                begin
                    code_next   = sym.symbol_code;
                    pack_next   = '0;
                    rad_sh_next = radix_eff;
                    pcnt_next   = PACK_CNT_W'(RADIX_W - 1);
                    state_next  = S_PACK;
                end
            end
            S_PACK:
            begin
                pack_next   = pack_step;
                rad_sh_next = {rad_sh_reg[RADIX_W-2:0], 1'b0};
                if (pcnt_reg == '0)
                    state_next = S_PACK_END;
                else
                    pcnt_next = pcnt_reg - 1'b1;
            end
            S_PACK_END:
            begin
                if (!block_done)
                begin
                    acc_next   = packed_word;
                    count_next = count_reg + 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    acc_next   = '0;
                    count_next = '0;
                    if (n_ok)
                    begin
                        // Reduce the block modulo n: 1 * packed_word mod n
                        mul_start  = 1'b1;
                        mul_a      = MOD_W'(1);
                        mul_b      = MUL_BITS'(packed_word);
                        state_next = S_RED_WAIT;
                    end
                    else
                    begin
                        r_next     = '0;
                        k_next     = ol_x;
                        state_next = S_DIV_GO;
                    end
                end
            end
            S_RED_WAIT:
            begin
                if (mul_stat.done)
                begin
                    bb_next    = mul_res;
                    r_next     = MOD_W'(1);
                    e_next     = exponent_reg;
                    state_next = S_EXP_CHECK;
                end
            end
            S_EXP_CHECK:
            begin
                if (e_reg == '0)
                begin
                    k_next     = ol_x;
                    state_next = S_DIV_GO;
                end
                else if (e_reg[0])
                begin
                    mul_start  = 1'b1;
                    mul_a      = r_reg;
                    mul_b      = MUL_BITS'(bb_reg);
                    state_next = S_MUL_WAIT;
                end
                else
                begin
                    mul_start  = 1'b1;
                    mul_a      = bb_reg;
                    mul_b      = MUL_BITS'(bb_reg);
                    state_next = S_SQR_WAIT;
                end
            end
            S_MUL_WAIT:
            begin
                if (mul_stat.done)
                begin
                    r_next     = mul_res;
                    state_next = S_SQR_GO;
                end
            end
            S_SQR_GO:
            begin
                mul_start  = 1'b1;
                mul_a      = bb_reg;
                mul_b      = MUL_BITS'(bb_reg);
                state_next = S_SQR_WAIT;
            end
            S_SQR_WAIT:
            begin
                if (mul_stat.done)
                begin
                    bb_next    = mul_res;
                    e_next     = e_reg >> 1;
                    state_next = S_EXP_CHECK;
                end
            end
            S_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    // Digits come out least significant first; store from the top slot down
                    dig_we = 1'b1;
                    r_next = div_quo;
                    k_next = k_reg - 1'b1;
                    if (k_reg == CMP_W'(1))
                    begin
                        idx_next   = '0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_DIV_GO;
                    end
                end
            end
            S_EMIT:
            begin
                if (dig_fire)
                begin
                    if (emit_last)
                        state_next = S_IDLE;
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control and block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            acc_reg   <= '0;
            count_reg <= '0;
            pcnt_reg  <= '0;
            k_reg     <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            count_reg <= count_next;
            pcnt_reg  <= pcnt_next;
            k_reg     <= k_next;
            idx_reg   <= idx_next;
        end
    end

    // Hold datapath registers and the digit buffer
    always_ff @(posedge clk)
    begin
        pack_reg   <= pack_next;
        rad_sh_reg <= rad_sh_next;
        code_reg   <= code_next;
        bb_reg     <= bb_next;
        r_reg      <= r_next;
        e_reg      <= e_next;
        if (dig_we)
            digit_mem[dig_widx] <= div_rem;
    end

    // Load the outgoing digit: the top digit straight from the divider, then the next slot
    always_ff @(posedge clk)
    begin
        if (dig_we && k_reg == CMP_W'(1))
            digit_out_reg <= div_rem;
        else if (dig_fire && !emit_last)
            digit_out_reg <= digit_mem[idx_next];
    end

    rbm_modmul #(
        .B_BITS (MUL_BITS)
    ) u_modmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .n      (modulus_reg),
        .stat   (mul_stat),
        .result (mul_res)
    );

    rbm_digdiv u_digdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (r_reg),
        .divisor   (radix_eff),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Drive the channels
    assign sym.ready      = sym_ready;
    assign dig.valid      = dig_valid;
    assign dig.digit_code = digit_out_reg;
    assign dig.block_end  = emit_last;

    `RBM_ASSERT(a_top_one_side, !(sym_ready && dig_valid), "intake open during emission")
    `RBM_ASSERT_NXT(a_top_end_idle, dig_fire && emit_last, sym_ready, "no return to intake")
    `RBM_ASSERT_IMP(a_top_emit_idx, dig_valid, CMP_W'(idx_reg) < ol_x, "digit index past block")

endmodule

/* rtl/rbm_modmul.sv */
// Bit-serial modular multiplier: result = a * b mod n, b scanned MSB first.
// Each bit of b takes a double-and-reduce step, then an add-and-reduce step. Uses rbm_pkg.
`include "assert_macros.svh"

module rbm_modmul
    import rbm_pkg::*;
#(
    parameter int B_BITS = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  mod_word_t         a,
    input  logic [B_BITS-1:0] b,
    input  mod_word_t         n,
    output unit_stat_t        stat,
    output mod_word_t         result
);

    localparam int CNT_W = $clog2(B_BITS);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              phase_reg, phase_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    mod_word_t         a_reg, a_next;
    mod_word_t         n_reg, n_next;
    mod_word_t         p_reg, p_next;
    logic [B_BITS-1:0] b_reg, b_next;

    logic [MOD_W:0] dbl, dbl_red, sum, sum_red, n_x;
    mod_word_t      addend;

    // Double, or add the selected multiplicand, with one conditional subtract each
    always_comb
    begin
        n_x     = {1'b0, n_reg};
        dbl     = {p_reg, 1'b0};
        dbl_red = (dbl >= n_x) ? (dbl - n_x) : dbl;
        addend  = b_reg[B_BITS-1] ? a_reg : '0;
        sum     = {1'b0, p_reg} + {1'b0, addend};
        sum_red = (sum >= n_x) ? (sum - n_x) : sum;
    end

    // Sequence the bit steps
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        a_next     = a_reg;
        n_next     = n_reg;
        p_next     = p_reg;
        b_next     = b_reg;
        if (start)
        begin
            a_next     = a;
            n_next     = n;
            b_next     = b;
            p_next     = '0;
            cnt_next   = CNT_W'(B_BITS - 1);
            phase_next = 1'b0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!phase_reg)
            begin
                p_next     = dbl_red[MOD_W-1:0];
                phase_next = 1'b1;
            end
            else
            begin
                p_next     = sum_red[MOD_W-1:0];
                b_next     = {b_reg[B_BITS-2:0], 1'b0};
                phase_next = 1'b0;
                if (cnt_reg == '0)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Hold operands and the partial result
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        n_reg <= n_next;
        p_reg <= p_next;
        b_reg <= b_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = p_reg;

    `RBM_ASSERT_IMP(a_mm_part_reduced, busy_reg, p_reg < n_reg, "partial product not reduced")
    `RBM_ASSERT_IMP(a_mm_result_reduced, done_reg, p_reg < n_reg, "result not below modulus")
    `RBM_ASSERT_IMP(a_mm_no_restart, start, !busy_reg, "multiplier started while busy")

endmodule

/* rtl/rbm_digdiv.sv */
// Restoring bit-serial divider: splits a word into quotient and one radix digit.
// One quotient bit per cycle over the 32-bit word. Uses rbm_pkg.
module rbm_digdiv
    import rbm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  mod_word_t          dividend,
    input  logic [RADIX_W-1:0] divisor,
    output unit_stat_t         stat,
    output mod_word_t          quotient,
    output logic [DIG_W-1:0]   remainder
);

    localparam int CNT_W = $clog2(MOD_W);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [RADIX_W-1:0] div_reg, div_next;
    logic [RADIX_W-1:0] rem_reg, rem_next;
    mod_word_t          quo_reg, quo_next;

    logic [RADIX_W:0] trial;
    logic             ge;

    // Shift in the next dividend bit and try the subtract
    always_comb
    begin
        trial = {rem_reg, quo_reg[MOD_W-1]};
        ge    = trial >= {1'b0, div_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            div_next  = divisor;
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(MOD_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? RADIX_W'(trial - {1'b0, div_reg}) : RADIX_W'(trial);
            quo_next = {quo_reg[MOD_W-2:0], ge};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold the working registers
    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    // Remainder stays below the radix, at most 256, so eight bits carry it
    assign remainder = rem_reg[DIG_W-1:0];

endmodule
